>>> hw/rtl/mips_subset_execute_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the execute unit checker.
// Each macro expands to one labeled concurrent assertion clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mseu_pkg.sv
// ----------------------------------------------------------------------------
// mseu_pkg
// Opcodes, constants, the execute result type and the load word builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mseu_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = 5;

  localparam logic [31:0] JUMP_KEEP_MASK = 32'hF800_0000;

  // Instruction codes.
  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLT = 6'd2, OP_SLTU = 6'd3,
    OP_AND = 6'd4, OP_OR = 6'd5, OP_XOR = 6'd6, OP_NOR = 6'd7,
    OP_SLLV = 6'd8, OP_SRLV = 6'd9, OP_SRAV = 6'd10, OP_SLL = 6'd11,
    OP_SRL = 6'd12, OP_SRA = 6'd13, OP_JR = 6'd14, OP_JALR = 6'd15,
    OP_SYSCALL = 6'd16, OP_ADDI = 6'd17, OP_SLTI = 6'd18, OP_SLTIU = 6'd19,
    OP_ANDI = 6'd20, OP_ORI = 6'd21, OP_XORI = 6'd22, OP_LUI = 6'd23,
    OP_LW = 6'd24, OP_LWX = 6'd25, OP_LH = 6'd26, OP_LHX = 6'd27,
    OP_LHU = 6'd28, OP_LHUX = 6'd29, OP_SW = 6'd30, OP_SWX = 6'd31,
    OP_SH = 6'd32, OP_SHX = 6'd33, OP_BEQ = 6'd34, OP_BNE = 6'd35,
    OP_J = 6'd36, OP_JAL = 6'd37
  } opcode_t;

  // Everything the execute logic decides for one instruction.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] val;
    logic        is_load;
    logic        is_store;
    logic        st_two;
    logic [15:0] h_a;
    logic [15:0] h_b;
    logic [1:0]  nstored;
    logic [31:0] maddr;
  } exec_t;

  // Builds a load result from the halfwords at the address and the next one.
  function automatic logic [31:0] load_word(input logic [5:0] op,
                                            input logic [15:0] h0,
                                            input logic [15:0] h1);
    logic [31:0] w;
    w = {16'h0000, h0};
    unique case (op)
      OP_LW:         w = {h0, h1};
      OP_LWX:        w = {h1, h0};
      OP_LH, OP_LHX: w = {{16{h0[15]}}, h0};
      default:       w = {16'h0000, h0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mseu_regfile.sv
// ----------------------------------------------------------------------------
// mseu_regfile
// Register file with two registered read ports, one write port and
// per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [mseu_pkg::REG_AW-1:0] ra,
  input  wire logic [mseu_pkg::REG_AW-1:0] rb,
  input  wire logic                       we,
  input  wire logic [mseu_pkg::REG_AW-1:0] wa,
  input  wire logic [31:0]                wd,
  output logic [31:0]                     qa,
  output logic [31:0]                     qb
);

  logic [31:0]                     mem [mseu_pkg::REG_COUNT];
  logic [mseu_pkg::REG_COUNT-1:0]  vld_r;
  logic [31:0]                     qa_r;
  logic [31:0]                     qb_r;

  // Valid bits: register zero is never written, so it always reads zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered reads; a write in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && wa == ra) begin
        qa_r <= wd;
      end else begin
        qa_r <= vld_r[ra] ? mem[ra] : 32'h0;
      end
      if (we && wa == rb) begin
        qb_r <= wd;
      end else begin
        qb_r <= vld_r[rb] ? mem[rb] : 32'h0;
      end
    end
  end

  assign qa = qa_r;
  assign qb = qb_r;

endmodule

`default_nettype wire

>>> hw/rtl/mseu_dmem.sv
// ----------------------------------------------------------------------------
// mseu_dmem
// Halfword data memory in two banks (even and odd addresses) so that a word
// access touches both halves in the same cycle. Clears itself after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_dmem #(
  parameter int MEM_HALFWORDS = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             rd_en,
  input  wire logic                             st_en,
  input  wire logic                             st_two,
  input  wire logic [$clog2(MEM_HALFWORDS)-1:0] addr,
  input  wire logic [15:0]                      h_a,
  input  wire logic [15:0]                      h_b,
  output logic [15:0]                           h0,
  output logic [15:0]                           h1,
  output logic                                  busy
);

  localparam int AW   = $clog2(MEM_HALFWORDS);
  localparam int RW   = AW - 1;
  localparam int ROWS = MEM_HALFWORDS / 2;

  logic [15:0]   even_mem [ROWS];
  logic [15:0]   odd_mem  [ROWS];
  logic [AW-1:0] addr1;
  logic [RW-1:0] even_row;
  logic [RW-1:0] odd_row;
  logic          even_we;
  logic          odd_we;
  logic [15:0]   even_wd;
  logic [15:0]   odd_wd;
  logic [15:0]   even_q_r;
  logic [15:0]   odd_q_r;
  logic          lsb_r;
  logic [RW-1:0] clr_row_r;
  logic          busy_r;

  // Bank steering for the address and the one after it.
  always_comb begin
    addr1    = addr + AW'(1);
    even_row = addr[0] ? addr1[AW-1:1] : addr[AW-1:1];
    odd_row  = addr[0] ? addr[AW-1:1] : addr1[AW-1:1];
    even_wd  = addr[0] ? h_b : h_a;
    odd_wd   = addr[0] ? h_a : h_b;
    even_we  = st_en && (!addr[0] || st_two);
    odd_we   = st_en && (addr[0] || st_two);
  end

  // Clearing sweep after reset, one row of both banks per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_row_r <= '0;
    end else if (busy_r) begin
      clr_row_r <= clr_row_r + RW'(1);
      if (clr_row_r == RW'(ROWS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Bank writes.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      even_mem[clr_row_r] <= 16'h0000;
      odd_mem[clr_row_r]  <= 16'h0000;
    end else begin
      if (even_we) begin
        even_mem[even_row] <= even_wd;
      end
      if (odd_we) begin
        odd_mem[odd_row] <= odd_wd;
      end
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q_r <= even_mem[even_row];
      odd_q_r  <= odd_mem[odd_row];
      lsb_r    <= addr[0];
    end
  end

  assign h0   = lsb_r ? odd_q_r : even_q_r;
  assign h1   = lsb_r ? even_q_r : odd_q_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

>>> hw/rtl/mseu_exec.sv
// ----------------------------------------------------------------------------
// mseu_exec
// Combinational execute logic: ALU, shifter, branch and jump targets,
// memory address and store data for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module mseu_exec (
  input  wire logic [5:0]      op,
  input  wire logic [4:0]      dest,
  input  wire logic [31:0]     a,
  input  wire logic [31:0]     b,
  input  wire logic [4:0]      sa,
  input  wire logic [15:0]     imm,
  input  wire logic [25:0]     target,
  input  wire logic [31:0]     pc,
  output mseu_pkg::exec_t      ex
);

  logic [31:0] imms;
  logic [31:0] immz;
  logic [31:0] jpc;
  logic [31:0] val;
  logic [4:0]  widx;
  logic        wr;

  always_comb begin
    imms = {{16{imm[15]}}, imm};
    immz = {16'h0000, imm};
    jpc  = (pc & mseu_pkg::JUMP_KEEP_MASK) | {6'b000000, target};
    val  = 32'h0;
    widx = dest;
    wr   = 1'b0;

    ex          = '0;
    ex.next_pc  = pc;
    ex.maddr    = a + imms;

    // Operation decode.
    unique case (op)
      mseu_pkg::OP_ADD:  begin val = a + b; wr = 1'b1; end
      mseu_pkg::OP_SUB:  begin val = a - b; wr = 1'b1; end
      mseu_pkg::OP_SLT:  begin val = {31'h0, $signed(a) < $signed(b)}; wr = 1'b1; end
      mseu_pkg::OP_SLTU: begin val = {31'h0, a < b}; wr = 1'b1; end
      mseu_pkg::OP_AND:  begin val = a & b; wr = 1'b1; end
      mseu_pkg::OP_OR:   begin val = a | b; wr = 1'b1; end
      mseu_pkg::OP_XOR:  begin val = a ^ b; wr = 1'b1; end
      mseu_pkg::OP_NOR:  begin val = ~(a | b); wr = 1'b1; end
      mseu_pkg::OP_SLLV: begin val = a << b[4:0]; wr = 1'b1; end
      mseu_pkg::OP_SRLV: begin val = a >> b[4:0]; wr = 1'b1; end
      mseu_pkg::OP_SRAV: begin val = $unsigned($signed(a) >>> b[4:0]); wr = 1'b1; end
      mseu_pkg::OP_SLL:  begin val = a << sa; wr = 1'b1; end
      mseu_pkg::OP_SRL:  begin val = a >> sa; wr = 1'b1; end
      mseu_pkg::OP_SRA:  begin val = $unsigned($signed(a) >>> sa); wr = 1'b1; end
      mseu_pkg::OP_JR:   begin ex.next_pc = a; end
      mseu_pkg::OP_JALR: begin val = pc; wr = 1'b1; ex.next_pc = a; end
      mseu_pkg::OP_ADDI: begin val = a + imms; wr = 1'b1; end
      mseu_pkg::OP_SLTI: begin val = {31'h0, $signed(a) < $signed(imms)}; wr = 1'b1; end
      mseu_pkg::OP_SLTIU: begin val = {31'h0, a < imms}; wr = 1'b1; end
      mseu_pkg::OP_ANDI: begin val = a & immz; wr = 1'b1; end
      mseu_pkg::OP_ORI:  begin val = a | immz; wr = 1'b1; end
      mseu_pkg::OP_XORI: begin val = a ^ immz; wr = 1'b1; end
      mseu_pkg::OP_LUI:  begin val = {imm, 16'h0000}; wr = 1'b1; end
      mseu_pkg::OP_LW, mseu_pkg::OP_LWX, mseu_pkg::OP_LH, mseu_pkg::OP_LHX,
      mseu_pkg::OP_LHU, mseu_pkg::OP_LHUX: begin
        wr = 1'b1;
        ex.is_load = 1'b1;
      end
      mseu_pkg::OP_SW: begin
        ex.is_store = 1'b1; ex.st_two = 1'b1; ex.nstored = 2'd2;
        ex.h_a = b[31:16]; ex.h_b = b[15:0];
      end
      mseu_pkg::OP_SWX: begin
        ex.is_store = 1'b1; ex.st_two = 1'b1; ex.nstored = 2'd2;
        ex.h_a = b[15:0]; ex.h_b = b[31:16];
      end
      mseu_pkg::OP_SH: begin
        ex.is_store = 1'b1; ex.nstored = 2'd1;
        ex.h_a = b[15:0];
      end
      mseu_pkg::OP_SHX: begin
        ex.is_store = 1'b1; ex.nstored = 2'd1;
        ex.h_a = {b[7:0], b[15:8]};
      end
      mseu_pkg::OP_BEQ: begin
        if (a == b) ex.next_pc = pc + imms;
      end
      mseu_pkg::OP_BNE: begin
        if (a != b) ex.next_pc = pc + imms;
      end
      mseu_pkg::OP_J:   begin ex.next_pc = jpc; end
      mseu_pkg::OP_JAL: begin val = pc; widx = 5'd31; wr = 1'b1; ex.next_pc = jpc; end
      default: begin end
    endcase

    // Writes to register zero are dropped and reported as no write.
    if (wr && widx != 5'd0) begin
      ex.wr   = 1'b1;
      ex.widx = widx;
      ex.val  = val;
    end else begin
      ex.wr      = 1'b0;
      ex.widx    = 5'd0;
      ex.val     = 32'h0;
      ex.is_load = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mips_subset_execute_unit_core.sv
// Flow: operands are read at the input transfer, then execute, then memory read, then result register.
// Throughput: one instruction per cycle unless a stalled output or the memory clear holds it back;
// each instruction sees all results of earlier ones. The register file and data memory read ports,
// with forwarding from the memory stage, set that rate.
// Reset: control state clears at once; the data memory then sweeps all MEM_HALFWORDS/2 rows
// (2048 at the default size) writing zeros while in_tready stays low. MEM_HALFWORDS: power of two.
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core
// Three-stage execute unit for a MIPS-like instruction subset with register
// file, halfword data memory and program counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_execute_unit_core #(
  parameter int MEM_HALFWORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[5:0], dest_reg[10:6], src_reg_a[15:11], src_reg_b[20:16],
  // shift_amount[25:21], immediate[41:26], jump_target[67:42], zero pad[71:68]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // next_pc[31:0], reg_written[32], written_index[37:33],
  // written_value[69:38], halfwords_stored[71:70], store_address[83:72],
  // zero pad[87:84]
  output logic [87:0]      out_tdata
);

  localparam int AW = $clog2(MEM_HALFWORDS);

  // Handshake and pipeline control.
  logic in_xfer;
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_free, s1_adv, s2_free, s2_adv, out_free;
  logic mem_busy;

  // Stage 1 payload.
  logic [5:0]  s1_op_r;
  logic [4:0]  s1_dest_r, s1_ra_r, s1_rb_r, s1_sa_r;
  logic [15:0] s1_imm_r;
  logic [25:0] s1_target_r;
  logic [31:0] pc_r;

  // Stage 2 payload.
  logic [5:0]  s2_op_r;
  logic        s2_wr_r, s2_load_r;
  logic [4:0]  s2_widx_r;
  logic [31:0] s2_val_r, s2_pc_r;
  logic [1:0]  s2_nstored_r;
  logic [11:0] s2_saddr_r;
  logic [31:0] s2_val;

  // Result register.
  logic [83:0] out_data_r;

  logic [31:0] rf_a, rf_b, op_a, op_b, addr_full;
  logic [15:0] h0, h1;
  mseu_pkg::exec_t ex;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s1_adv;
  assign in_tready = !mem_busy && s1_free;
  assign in_xfer   = in_tvalid && in_tready;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= 32'h0;
    end else begin
      if (s1_free) s1_valid_r <= in_xfer;
      if (s2_free) s2_valid_r <= s1_adv;
      if (out_free) out_valid_r <= s2_adv;
      if (s1_adv) pc_r <= ex.next_pc;
    end
  end

  // Stage 1: capture the instruction fields.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_tdata[5:0];
      s1_dest_r   <= in_tdata[10:6];
      s1_ra_r     <= in_tdata[15:11];
      s1_rb_r     <= in_tdata[20:16];
      s1_sa_r     <= in_tdata[25:21];
      s1_imm_r    <= in_tdata[41:26];
      s1_target_r <= in_tdata[67:42];
    end
  end

  mseu_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_xfer),
    .ra    (in_tdata[15:11]),
    .rb    (in_tdata[20:16]),
    .we    (s2_adv && s2_wr_r),
    .wa    (s2_widx_r),
    .wd    (s2_val),
    .qa    (rf_a),
    .qb    (rf_b)
  );

  // Forward the result still in the memory stage.
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (s2_valid_r && s2_wr_r && s2_widx_r == s1_ra_r) op_a = s2_val;
    if (s2_valid_r && s2_wr_r && s2_widx_r == s1_rb_r) op_b = s2_val;
  end

  mseu_exec u_exec (
    .op     (s1_op_r),
    .dest   (s1_dest_r),
    .a      (op_a),
    .b      (op_b),
    .sa     (s1_sa_r),
    .imm    (s1_imm_r),
    .target (s1_target_r),
    .pc     (pc_r),
    .ex     (ex)
  );

  // Address modulo the memory size.
  assign addr_full = ex.maddr & 32'(MEM_HALFWORDS - 1);

  mseu_dmem #(.MEM_HALFWORDS(MEM_HALFWORDS)) u_dmem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (s1_adv && ex.is_load),
    .st_en  (s1_adv && ex.is_store),
    .st_two (ex.st_two),
    .addr   (addr_full[AW-1:0]),
    .h_a    (ex.h_a),
    .h_b    (ex.h_b),
    .h0     (h0),
    .h1     (h1),
    .busy   (mem_busy)
  );

  // Stage 2: memory read in flight.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_op_r      <= s1_op_r;
      s2_wr_r      <= ex.wr;
      s2_load_r    <= ex.is_load;
      s2_widx_r    <= ex.widx;
      s2_val_r     <= ex.val;
      s2_pc_r      <= ex.next_pc;
      s2_nstored_r <= ex.nstored;
      s2_saddr_r   <= ex.is_store ? addr_full[11:0] : 12'h000;
    end
  end

  assign s2_val = s2_load_r ? mseu_pkg::load_word(s2_op_r, h0, h1) : s2_val_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r <= {s2_saddr_r, s2_nstored_r, s2_val, s2_widx_r, s2_wr_r, s2_pc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_data_r};

endmodule

`default_nettype wire

>>> hw/rtl/mseu_checker.sv
// ----------------------------------------------------------------------------
// mseu_checker
// Port-level checks on the result channel of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mips_subset_execute_unit_core_defines.svh"

module mseu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);

  // A stalled result holds.
  `MSEU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // No register write reports index and value of zero.
  `MSEU_ASSERT_NOW(a_nowrite_zero, out_tvalid && !out_tdata[32], out_tdata[69:33] == 37'h0, "no-write result carries data")

  // A register write never targets register zero.
  `MSEU_ASSERT_NOW(a_write_nonzero, out_tvalid && out_tdata[32], out_tdata[37:33] != 5'd0, "write to register zero reported")

  // Non-store results carry a zero store address; stores never write three halves.
  `MSEU_ASSERT_NOW(a_store_fields, out_tvalid, (out_tdata[71:70] != 2'd3) && (out_tdata[71:70] != 2'd0 || out_tdata[83:72] == 12'h0), "bad store fields")

endmodule

bind mips_subset_execute_unit_core mseu_checker u_mseu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> verif/mips_subset_execute_unit_core_checker.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core_checker
// Watches both stream channels of the execute unit, keeps its own copy of the
// register file, halfword memory and program counter, predicts each result
// and compares it field by field with what the unit offers.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_core_checker #(
  parameter int MEM_HALFWORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [87:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [11:0] store_address;
    logic [1:0]  halfwords_stored;
    logic [31:0] written_value;
    logic [4:0]  written_index;
    logic        reg_written;
    logic [31:0] next_pc;
  } exec_result_t;

  logic [31:0] shadow_regs [mseu_pkg::REG_COUNT];
  logic [15:0] shadow_mem [MEM_HALFWORDS];
  logic [31:0] shadow_pc;
  exec_result_t expected_results [$];

  initial fail_count = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] read_reg(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : shadow_regs[idx];
  endfunction

  function automatic logic [31:0] sra_word(input logic [31:0] v, input logic [4:0] sh);
    return $unsigned($signed(v) >>> sh);
  endfunction

  // Execute one instruction against the shadow state.
  task automatic execute_instruction(input logic [71:0] d);
    logic [5:0]  op;
    logic [4:0]  rd, sa;
    logic [31:0] a, b, immz, imms, val, pc, addr, addr1;
    logic [25:0] target;
    logic        wr;
    logic [4:0]  widx;
    logic [1:0]  nst;
    exec_result_t r;
    op = d[5:0];
    rd = d[10:6];
    a = read_reg(d[15:11]);
    b = read_reg(d[20:16]);
    sa = d[25:21];
    immz = {16'd0, d[41:26]};
    imms = {{16{d[41]}}, d[41:26]};
    target = d[67:42];
    addr = (a + imms) % MEM_HALFWORDS;
    addr1 = (addr + 1) % MEM_HALFWORDS;
    pc = shadow_pc;
    val = 0;
    widx = rd;
    wr = 1'b0;
    nst = 2'd0;
    case (op)
      mseu_pkg::OP_ADD:   begin val = a + b; wr = 1; end
      mseu_pkg::OP_SUB:   begin val = a - b; wr = 1; end
      mseu_pkg::OP_SLT:   begin val = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1; end
      mseu_pkg::OP_SLTU:  begin val = (a < b) ? 1 : 0; wr = 1; end
      mseu_pkg::OP_AND:   begin val = a & b; wr = 1; end
      mseu_pkg::OP_OR:    begin val = a | b; wr = 1; end
      mseu_pkg::OP_XOR:   begin val = a ^ b; wr = 1; end
      mseu_pkg::OP_NOR:   begin val = ~(a | b); wr = 1; end
      mseu_pkg::OP_SLLV:  begin val = a << b[4:0]; wr = 1; end
      mseu_pkg::OP_SRLV:  begin val = a >> b[4:0]; wr = 1; end
      mseu_pkg::OP_SRAV:  begin val = sra_word(a, b[4:0]); wr = 1; end
      mseu_pkg::OP_SLL:   begin val = a << sa; wr = 1; end
      mseu_pkg::OP_SRL:   begin val = a >> sa; wr = 1; end
      mseu_pkg::OP_SRA:   begin val = sra_word(a, sa); wr = 1; end
      mseu_pkg::OP_JR:    pc = a;
      mseu_pkg::OP_JALR:  begin val = pc; wr = 1; pc = a; end
      mseu_pkg::OP_ADDI:  begin val = a + imms; wr = 1; end
      mseu_pkg::OP_SLTI:  begin val = ($signed(a) < $signed(imms)) ? 1 : 0; wr = 1; end
      mseu_pkg::OP_SLTIU: begin val = (a < imms) ? 1 : 0; wr = 1; end
      mseu_pkg::OP_ANDI:  begin val = a & immz; wr = 1; end
      mseu_pkg::OP_ORI:   begin val = a | immz; wr = 1; end
      mseu_pkg::OP_XORI:  begin val = a ^ immz; wr = 1; end
      mseu_pkg::OP_LUI:   begin val = immz << 16; wr = 1; end
      mseu_pkg::OP_LW:    begin val = {shadow_mem[addr], shadow_mem[addr1]}; wr = 1; end
      mseu_pkg::OP_LWX:   begin val = {shadow_mem[addr1], shadow_mem[addr]}; wr = 1; end
      mseu_pkg::OP_LH, mseu_pkg::OP_LHX: begin
        val = {{16{shadow_mem[addr][15]}}, shadow_mem[addr]}; wr = 1;
      end
      mseu_pkg::OP_LHU, mseu_pkg::OP_LHUX: begin
        val = {16'd0, shadow_mem[addr]}; wr = 1;
      end
      mseu_pkg::OP_SW: begin
        shadow_mem[addr] = b[31:16]; shadow_mem[addr1] = b[15:0]; nst = 2;
      end
      mseu_pkg::OP_SWX: begin
        shadow_mem[addr1] = b[31:16]; shadow_mem[addr] = b[15:0]; nst = 2;
      end
      mseu_pkg::OP_SH:    begin shadow_mem[addr] = b[15:0]; nst = 1; end
      mseu_pkg::OP_SHX:   begin shadow_mem[addr] = {b[7:0], b[15:8]}; nst = 1; end
      mseu_pkg::OP_BEQ:   if (a == b) pc = pc + imms;
      mseu_pkg::OP_BNE:   if (a != b) pc = pc + imms;
      mseu_pkg::OP_J:     pc = (pc & mseu_pkg::JUMP_KEEP_MASK) | target;
      mseu_pkg::OP_JAL: begin
        val = pc; widx = 5'd31; wr = 1; pc = (pc & mseu_pkg::JUMP_KEEP_MASK) | target;
      end
      default: ;
    endcase
    // Writes to register zero are dropped and reported as no write.
    if (wr && widx != 0) shadow_regs[widx] = val;
    else begin wr = 0; widx = 0; val = 0; end
    shadow_pc = pc;
    r.next_pc = pc;
    r.reg_written = wr;
    r.written_index = widx;
    r.written_value = val;
    r.halfwords_stored = nst;
    r.store_address = (nst != 0) ? addr[11:0] : 12'd0;
    expected_results.insert(expected_results.size(), r);
  endtask

  // Predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] = 0;
      foreach (shadow_mem[i]) shadow_mem[i] = 0;
      shadow_pc = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) execute_instruction(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata[83:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", got.next_pc, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.next_pc != want.next_pc)
            report_mismatch("next_pc", got.next_pc, want.next_pc);
          if (got.reg_written != want.reg_written)
            report_mismatch("reg_written", got.reg_written, want.reg_written);
          if (got.written_index != want.written_index)
            report_mismatch("written_index", got.written_index, want.written_index);
          if (got.written_value != want.written_value)
            report_mismatch("written_value", got.written_value, want.written_value);
          if (got.halfwords_stored != want.halfwords_stored)
            report_mismatch("halfwords_stored", got.halfwords_stored,
                            want.halfwords_stored);
          if (got.store_address != want.store_address)
            report_mismatch("store_address", got.store_address, want.store_address);
        end
        if (out_tdata[87:84] != 4'd0) report_mismatch("pad", out_tdata[87:84], 0);
      end
    end
    pending = expected_results.size();
  end
endmodule

>>> verif/mips_subset_execute_unit_core_tb.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core_tb
// Drives directed and random instruction streams into the execute unit under
// varying idle patterns on both channels; the checker judges every result.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_core_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 37;
  int          recv_idle_pct = 65;

  always #10 clk = ~clk;

  mips_subset_execute_unit_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  mips_subset_execute_unit_core_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls at random.
  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [71:0] pack_instr(input logic [5:0] op, input logic [4:0] rd,
                                             input logic [4:0] rs, input logic [4:0] rt,
                                             input logic [4:0] sa, input logic [15:0] imm,
                                             input logic [25:0] tgt);
    return {4'd0, tgt, imm, sa, rt, rs, rd, op};
  endfunction

  // Offer one instruction, with a random gap first, and hold it until its transfer.
  task automatic send_instr(input logic [71:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random instruction: mostly valid codes, a few undefined ones, registers
  // kept mostly low so results feed later instructions.
  task automatic send_random;
    logic [5:0]  op;
    logic [4:0]  rd, rs, rt;
    logic [15:0] imm;
    op = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 38)) : 6'($urandom_range(37));
    rd = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    rs = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    rt = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    imm = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($signed(8'($urandom)));
    send_instr(pack_instr(op, rd, rs, rt, 5'($urandom), imm, 26'($urandom)));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Directed part: extremes, loads from stores, swapped forms, links, r0.
    send_instr(pack_instr(mseu_pkg::OP_LUI, 5'd1, 5'd0, 5'd0, 5'd0, 16'hFFFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_ORI, 5'd1, 5'd1, 5'd0, 5'd0, 16'hFFFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_ADDI, 5'd2, 5'd0, 5'd0, 5'd0, 16'h8000, '0));
    send_instr(pack_instr(mseu_pkg::OP_ADDI, 5'd3, 5'd0, 5'd0, 5'd0, 16'h7FFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_SRA, 5'd4, 5'd2, 5'd0, 5'd31, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_SRAV, 5'd5, 5'd2, 5'd3, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_SLT, 5'd6, 5'd2, 5'd3, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_SLTIU, 5'd7, 5'd3, 5'd0, 5'd0, 16'h8000, '0));
    send_instr(pack_instr(mseu_pkg::OP_SW, 5'd0, 5'd0, 5'd1, 5'd0, 16'hFFFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_LW, 5'd8, 5'd0, 5'd0, 5'd0, 16'hFFFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_SWX, 5'd0, 5'd3, 5'd2, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_LWX, 5'd9, 5'd3, 5'd0, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_SHX, 5'd0, 5'd0, 5'd3, 5'd0, 16'd5, '0));
    send_instr(pack_instr(mseu_pkg::OP_LH, 5'd10, 5'd0, 5'd0, 5'd0, 16'd5, '0));
    send_instr(pack_instr(mseu_pkg::OP_LHUX, 5'd11, 5'd0, 5'd0, 5'd0, 16'd5, '0));
    send_instr(pack_instr(mseu_pkg::OP_SH, 5'd0, 5'd0, 5'd2, 5'd0, 16'd6, '0));
    send_instr(pack_instr(mseu_pkg::OP_LHU, 5'd12, 5'd0, 5'd0, 5'd0, 16'd6, '0));
    send_instr(pack_instr(mseu_pkg::OP_ADD, 5'd0, 5'd1, 5'd1, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_JAL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0, 26'h3FFFFFF));
    send_instr(pack_instr(mseu_pkg::OP_BNE, 5'd0, 5'd1, 5'd0, 5'd0, 16'h8000, '0));
    send_instr(pack_instr(mseu_pkg::OP_BEQ, 5'd0, 5'd0, 5'd0, 5'd0, 16'h7FFF, '0));
    send_instr(pack_instr(mseu_pkg::OP_JALR, 5'd13, 5'd2, 5'd0, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_JR, 5'd0, 5'd31, 5'd0, 5'd0, 16'd0, '0));
    send_instr(pack_instr(mseu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0, '0));
    send_instr(pack_instr(6'd63, 5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF, 26'h3FFFFFF));
    // Hold off until every result is back.
    drain();
    // Random part over three idle patterns.
    repeat (480) send_random();
    send_idle_pct = 65;
    recv_idle_pct = 37;
    repeat (480) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (480) send_random();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("mips_subset_execute_unit_core: match");
    else $display("mips_subset_execute_unit_core: mismatch");
    $finish;
  end

  // Run time limit.
  initial begin
    #4000000;
    $display("mips_subset_execute_unit_core: mismatch");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mseu_pkg.sv
hw/rtl/mseu_regfile.sv
hw/rtl/mseu_dmem.sv
hw/rtl/mseu_exec.sv
hw/rtl/mips_subset_execute_unit_core.sv
hw/rtl/mseu_checker.sv
verif/mips_subset_execute_unit_core_checker.sv
verif/mips_subset_execute_unit_core_tb.sv
